FILE: hdl/tac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_pkg: shared definitions for the temperature alarm controller
// Types, register indexes, band codes and reset values used by all modules.
// ----------------------------------------------------------------------------
package tac_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int TEMP_W     = 12;
    localparam int THR_W      = 9;
    localparam int RELAY_W    = 13;
    localparam int BUZZ_W     = 14;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_THRESHOLD  = 3'd0,
        CFG_OFF_THRESHOLD = 3'd1,
        CFG_RELAY_BEEP    = 3'd2,
        CFG_ALERT_BEEP    = 3'd3,
        CFG_TEMP_CONTROL  = 3'd4
    } t_cfg_idx;

    // Register reset values.
    localparam logic [THR_W-1:0]   RST_ON_THRESHOLD  = 9'd300;
    localparam logic [THR_W-1:0]   RST_OFF_THRESHOLD = 9'd280;
    localparam logic [RELAY_W-1:0] RST_RELAY_BEEP    = 13'd1000;
    localparam logic [BUZZ_W-1:0]  RST_ALERT_BEEP    = 14'd5000;
    localparam logic               RST_TEMP_CONTROL  = 1'b1;

    // Command codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Temperature band codes.
    localparam logic [1:0] BAND_UNKNOWN = 2'd0;
    localparam logic [1:0] BAND_LOW     = 2'd1;
    localparam logic [1:0] BAND_MIDDLE  = 2'd2;
    localparam logic [1:0] BAND_HIGH    = 2'd3;

    // Read counts for fault entry, fault recovery and band confirmation.
    localparam logic [1:0] FAULT_READS   = 2'd3;
    localparam logic [1:0] RECOVER_READS = 2'd3;
    localparam logic [1:0] CONFIRM_READS = 2'd2;
    localparam logic [1:0] COUNT_MAX     = 2'd3;

    typedef struct packed {
        logic [THR_W-1:0]   on_threshold;
        logic [THR_W-1:0]   off_threshold;
        logic [RELAY_W-1:0] relay_beep_ticks;
        logic [BUZZ_W-1:0]  alert_beep_ticks;
        logic               temp_control;
    } t_cfg;

    typedef struct packed {
        logic                     command;
        logic                     read_ok;
        logic signed [TEMP_W-1:0] temperature;
    } t_item;

    typedef struct packed {
        logic       relay_drive;
        logic       buzzer_sounding;
        logic       sensor_fault;
        logic       sensor_healthy;
        logic [1:0] current_band;
        logic       band_changed;
    } t_result;

endpackage

FILE: hdl/tac_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_in_if: request channel of the temperature alarm controller
// Carries a tick or a sensor read result with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tac_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        read_ok;
    logic signed [11:0] temperature;

    modport source (output valid, output command, output read_ok,
                    output temperature, input ready);
    modport sink   (input valid, input command, input read_ok,
                    input temperature, output ready);
endinterface

FILE: hdl/tac_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_out_if: result channel of the temperature alarm controller
// Carries relay, buzzer, fault and band status with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tac_out_if;
    logic       valid;
    logic       ready;
    logic       relay_drive;
    logic       buzzer_sounding;
    logic       sensor_fault;
    logic       sensor_healthy;
    logic [1:0] current_band;
    logic       band_changed;

    modport source (output valid, output relay_drive, output buzzer_sounding,
                    output sensor_fault, output sensor_healthy,
                    output current_band, output band_changed, input ready);
    modport sink   (input valid, input relay_drive, input buzzer_sounding,
                    input sensor_fault, input sensor_healthy,
                    input current_band, input band_changed, output ready);
endinterface

FILE: hdl/tac_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_cfg_regs: configuration register file
// Holds thresholds, beep times and the mode bit, written by index.
// ----------------------------------------------------------------------------
module tac_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tac_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tac_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output tac_pkg::t_cfg                    o_cfg
);
    import tac_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_threshold     <= RST_ON_THRESHOLD;
            r_cfg.off_threshold    <= RST_OFF_THRESHOLD;
            r_cfg.relay_beep_ticks <= RST_RELAY_BEEP;
            r_cfg.alert_beep_ticks <= RST_ALERT_BEEP;
            r_cfg.temp_control     <= RST_TEMP_CONTROL;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ON_THRESHOLD:  r_cfg.on_threshold     <= i_cfg_data[THR_W-1:0];
                CFG_OFF_THRESHOLD: r_cfg.off_threshold    <= i_cfg_data[THR_W-1:0];
                CFG_RELAY_BEEP:    r_cfg.relay_beep_ticks <= i_cfg_data[RELAY_W-1:0];
                CFG_ALERT_BEEP:    r_cfg.alert_beep_ticks <= i_cfg_data[BUZZ_W-1:0];
                CFG_TEMP_CONTROL:  r_cfg.temp_control     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/tac_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_engine: controller state and single-pass update
// Updates fault, relay, band and buzzer state, one item per i_step cycle.
// ----------------------------------------------------------------------------
module tac_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  tac_pkg::t_item    i_item,
    input  tac_pkg::t_cfg     i_cfg,
    output tac_pkg::t_result  o_result
);
    import tac_pkg::*;

    typedef struct packed {
        logic              active;
        logic [BUZZ_W-1:0] remaining;
    } t_buzz;

    logic [1:0]        r_fail, n_fail;
    logic [1:0]        r_recover, n_recover;
    logic              r_fault, n_fault;
    logic              r_healthy, n_healthy;
    logic              r_relay, n_relay;
    logic [1:0]        r_band, n_band;
    logic [1:0]        r_cand, n_cand;
    logic [1:0]        r_conf, n_conf;
    logic              r_buzz_active;
    logic [BUZZ_W-1:0] r_buzz_rem;
    t_buzz             n_buzz;
    logic              c_changed;
    logic              c_accept;
    logic              c_ge_on;
    logic              c_le_off;
    logic [1:0]        c_read_band;
    logic [1:0]        c_conf_inc;

    // A start never shortens a longer time still left; zero means no beep.
    function automatic t_buzz buzz_start(t_buzz cur, logic [BUZZ_W-1:0] ticks);
        t_buzz res;
        res = cur;
        if (ticks != '0 && !(cur.active && cur.remaining >= ticks)) begin
            res.active    = 1'b1;
            res.remaining = ticks;
        end
        return res;
    endfunction

    assign c_ge_on  = i_item.temperature >= $signed({3'b000, i_cfg.on_threshold});
    assign c_le_off = i_item.temperature <= $signed({3'b000, i_cfg.off_threshold});
    assign c_read_band = c_le_off ? BAND_LOW : (c_ge_on ? BAND_HIGH : BAND_MIDDLE);
    assign c_conf_inc  = (r_conf == COUNT_MAX) ? COUNT_MAX : r_conf + 2'd1;

    always_comb begin
        n_fail     = r_fail;
        n_recover  = r_recover;
        n_fault    = r_fault;
        n_healthy  = r_healthy;
        n_relay    = r_relay;
        n_band     = r_band;
        n_cand     = r_cand;
        n_conf     = r_conf;
        n_buzz.active    = r_buzz_active;
        n_buzz.remaining = r_buzz_rem;
        c_changed  = 1'b0;
        c_accept   = 1'b1;

        if (i_item.command == CMD_TICK) begin
            if (r_buzz_active) begin
                if (r_buzz_rem != '0) begin
                    n_buzz.remaining = r_buzz_rem - BUZZ_W'(1);
                end
                if (n_buzz.remaining == '0) begin
                    n_buzz.active = 1'b0;
                end
            end
        end else if (!i_item.read_ok) begin
            n_fail    = (r_fail == COUNT_MAX) ? COUNT_MAX : r_fail + 2'd1;
            n_recover = '0;
            if (n_fail >= FAULT_READS) begin
                n_fault   = 1'b1;
                n_healthy = 1'b0;
                // The sensor is now faulty, so auto mode forces the relay off.
                if (i_cfg.temp_control && r_relay) begin
                    n_relay = 1'b0;
                    n_buzz  = buzz_start(n_buzz, {1'b0, i_cfg.relay_beep_ticks});
                end
            end
        end else begin
            n_fail = '0;
            if (r_fault) begin
                n_recover = (r_recover == COUNT_MAX) ? COUNT_MAX : r_recover + 2'd1;
                if (n_recover < RECOVER_READS) begin
                    c_accept = 1'b0;
                end else begin
                    n_fault = 1'b0;
                    n_band  = BAND_UNKNOWN;
                end
            end
            if (c_accept) begin
                n_healthy = 1'b1;
                // Sensor is healthy and fault-free here: plain hysteresis.
                if (i_cfg.temp_control) begin
                    if (c_ge_on) begin
                        if (!r_relay) begin
                            n_relay = 1'b1;
                            n_buzz  = buzz_start(n_buzz, {1'b0, i_cfg.relay_beep_ticks});
                        end
                    end else if (c_le_off) begin
                        if (r_relay) begin
                            n_relay = 1'b0;
                            n_buzz  = buzz_start(n_buzz, {1'b0, i_cfg.relay_beep_ticks});
                        end
                    end
                end
                if (n_band == BAND_UNKNOWN) begin
                    n_band = c_read_band;
                    n_cand = c_read_band;
                    n_conf = '0;
                end else if (c_read_band == n_band) begin
                    n_cand = c_read_band;
                    n_conf = '0;
                end else if (c_read_band != r_cand) begin
                    n_cand = c_read_band;
                    n_conf = 2'd1;
                end else if (c_conf_inc >= CONFIRM_READS) begin
                    n_band    = c_read_band;
                    n_conf    = '0;
                    n_buzz    = buzz_start(n_buzz, i_cfg.alert_beep_ticks);
                    c_changed = 1'b1;
                end else begin
                    n_conf = c_conf_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail        <= '0;
            r_recover     <= '0;
            r_fault       <= 1'b0;
            r_healthy     <= 1'b0;
            r_relay       <= 1'b0;
            r_band        <= BAND_UNKNOWN;
            r_cand        <= BAND_UNKNOWN;
            r_conf        <= '0;
            r_buzz_active <= 1'b0;
            r_buzz_rem    <= '0;
        end else if (i_step) begin
            r_fail        <= n_fail;
            r_recover     <= n_recover;
            r_fault       <= n_fault;
            r_healthy     <= n_healthy;
            r_relay       <= n_relay;
            r_band        <= n_band;
            r_cand        <= n_cand;
            r_conf        <= n_conf;
            r_buzz_active <= n_buzz.active;
            r_buzz_rem    <= n_buzz.remaining;
        end
    end

    assign o_result.relay_drive     = n_relay;
    assign o_result.buzzer_sounding = n_buzz.active;
    assign o_result.sensor_fault    = n_fault;
    assign o_result.sensor_healthy  = n_healthy;
    assign o_result.current_band    = n_band;
    assign o_result.band_changed    = c_changed;

`ifndef ASSERT_OFF
    a_fault_not_healthy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |-> !r_healthy)
        else $error("fault and healthy flags both set");

    a_buzz_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buzz_active == (r_buzz_rem != '0))
        else $error("buzzer active flag disagrees with remaining time");

    a_unknown_band_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_band == BAND_UNKNOWN) |-> (r_conf == '0))
        else $error("confirmation running without an accepted band");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_band) && $stable(r_relay) && $stable(r_buzz_rem))
        else $error("state moved without an item");
`endif

endmodule

FILE: hdl/temperature_alarm_controller.sv
`timescale 1ns / 1ps
// An accepted request waits in the input register until the result stage is
// free; the state update then commits and its result is registered on o_res.
// Throughput: one request per cycle; the input register, state update and
// result register form a two-stage pipeline that stalls only on o_res.ready.
// Reset (i_rst_n low, synchronous) clears all controller state, empties both
// stages and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
// temperature_alarm_controller: sensor fault, relay and buzzer control
// Tracks sensor health, drives a hysteresis relay and times buzzer alerts.
// ----------------------------------------------------------------------------
module temperature_alarm_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tac_in_if.sink                           i_req,
    tac_out_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [tac_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tac_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tac_pkg::*;

    // Stage one holds the accepted request. Stage two holds the finished
    // result. The state update sits between them and commits in the same
    // cycle the result is captured, so the next request always sees the
    // state left by the one before it.
    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;

    t_cfg    c_cfg;
    t_result c_result;
    logic    c_out_free;
    logic    c_advance;

    tac_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (c_cfg)
    );

    tac_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (c_advance),
        .i_item   (r_in_item),
        .i_cfg    (c_cfg),
        .o_result (c_result)
    );

    // The result stage can take a new result when it is empty or its current
    // result leaves in this cycle. The request stage moves on under the same
    // condition, so a request already inside waits, unchanged, while a
    // result is held on o_res.
    assign c_out_free = !r_out_valid || o_res.ready;
    assign c_advance  = r_in_valid && c_out_free;
    assign i_req.ready = !r_in_valid || c_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (c_out_free) begin
                r_out_valid <= c_advance;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_item.command     <= i_req.command;
            r_in_item.read_ok     <= i_req.read_ok;
            r_in_item.temperature <= i_req.temperature;
        end
        if (c_advance) begin
            r_out <= c_result;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.relay_drive     = r_out.relay_drive;
    assign o_res.buzzer_sounding = r_out.buzzer_sounding;
    assign o_res.sensor_fault    = r_out.sensor_fault;
    assign o_res.sensor_healthy  = r_out.sensor_healthy;
    assign o_res.current_band    = r_out.current_band;
    assign o_res.band_changed    = r_out.band_changed;

`ifndef ASSERT_OFF
    a_result_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_advance |=> r_out_valid)
        else $error("processed request produced no result");

    a_no_result_without_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a request in stage one");

    a_stall_holds_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !c_advance) |=> r_in_valid && $stable(r_in_item))
        else $error("stalled request was lost or changed");
`endif

endmodule
